### src/atcd_pkg.sv
// Package for the AT command line dispatcher.
// Holds word types, phase and controller encodings, and the hash step.
`default_nettype none
package atcd_pkg;
  localparam int Entries = 16;
  localparam int NameMax = 64;
  localparam int HashWidth = 32;
  localparam int IdxW = $clog2(Entries);
  localparam int LenW = $clog2(NameMax + 2);
  localparam logic [HashWidth-1:0] HashSeed = HashWidth'(5381);
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChEquals = 8'h3D;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0, KIND_DISPATCH = 2'd1, KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NO_MARKER = 3'd0, ERR_EQ_LAST = 3'd1, ERR_NO_MATCH = 3'd2,
    ERR_NO_HANDLER = 3'd3, ERR_TOO_LONG = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    PH_SEEK = 3'd0, PH_NAME = 3'd1, PH_READ = 3'd2, PH_EQ = 3'd3,
    PH_TEST = 3'd4, PH_WRITE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ECHO, ST_FINISH, ST_WALK, ST_EMIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic       last_char;
    logic [3:0] handler_mask;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] request_type;
    logic [3:0] entry_index;
    logic [7:0] value_char;
    logic [2:0] error_cause;
    logic       last_result;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic walk_start;
    logic walk_step;
    logic load_result;
    logic clear_line;
  } cmd_t;

  typedef struct packed {
    logic       echo;
    logic       last;
    logic       is_reg;
    logic       early_error;
    logic       walk_end;
    logic       hit;
    logic       hit_missing;
    logic       matched;
  } stat_t;

  function automatic logic [HashWidth-1:0] hash_in(logic [HashWidth-1:0] h,
                                                   logic [7:0] c);
    hash_in = (h << 5) + h + HashWidth'(c);
  endfunction
endpackage
`default_nettype wire

### src/atcd_datapath.sv
// Datapath: marker search, name hash, entry table and walk pointer.
// Depends on atcd_pkg; driven by atcd_ctrl commands.
`default_nettype none
module atcd_datapath (
  input  wire                   clk,
  input  wire                   rst,
  input  wire [23:0]            marker_chars,
  input  atcd_pkg::in_word_t    in_word,
  input  atcd_pkg::cmd_t        cmd,
  output atcd_pkg::stat_t       stat,
  output logic                  later_hit,
  output atcd_pkg::out_word_t   result
);
  import atcd_pkg::*;

  logic [HashWidth-1:0] entry_hash [Entries];
  logic [3:0]           entry_handlers [Entries];
  logic [HashWidth-1:0] name_hash;
  phase_t               phase;
  logic [1:0]           progress;
  logic [LenW-1:0]      name_length;
  logic [IdxW:0]        walk_idx;
  logic                 matched;
  logic [1:0]           rtype;
  logic [HashWidth-1:0] hash_step;
  logic [1:0]           mnext;
  logic [7:0]           m0, m1, m2;
  logic [IdxW-1:0]      free_idx;
  logic                 free_found;
  logic                 echo_now;
  logic [LenW-1:0]      len_inc;
  logic [IdxW-1:0]      widx;
  logic                 whit;

  assign m0 = marker_chars[23:16];
  assign m1 = marker_chars[15:8];
  assign m2 = marker_chars[7:0];
  assign hash_step = hash_in(name_hash, in_word.char_code);
  assign len_inc = (name_length <= LenW'(NameMax)) ? name_length + 1'b1 : name_length;
  assign widx = walk_idx[IdxW-1:0];
  assign whit = entry_hash[widx] == name_hash;

  always_comb begin
    logic [7:0] c;
    c = in_word.char_code;
    mnext = 2'd0;
    if (progress == 2'd2 && m0 == m1 && c == m2) mnext = 2'd3;
    else if (progress == 2'd2 && m0 != m1 && c == m2) mnext = 2'd3;
    else if (progress == 2'd1 && c == m1) mnext = 2'd2;
    else if (progress == 2'd2 && m1 == m0 && m0 == m1 && c == m1) mnext = 2'd2;
    else if (c == m0) mnext = 2'd1;
    if (progress == 2'd2 && c != m2) begin
      if (m1 == m0 && c == m1 && m0 == m1) mnext = 2'd2;
      else if (c == m0) mnext = 2'd1;
      else mnext = 2'd0;
    end
  end

  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (entry_hash[i] == '0) begin
        free_idx = IdxW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    later_hit = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (IdxW'(i) > widx && entry_hash[i] == name_hash) later_hit = 1'b1;
    end
  end

  always_comb begin
    echo_now = 1'b0;
    if (!in_word.opcode) begin
      if (phase == PH_WRITE) echo_now = 1'b1;
      else if (phase == PH_EQ && in_word.char_code != ChQuestion) echo_now = 1'b1;
    end
  end

  always_comb begin
    unique case (phase)
      PH_READ:  rtype = 2'd1;
      PH_TEST:  rtype = 2'd2;
      PH_WRITE: rtype = 2'd3;
      default:  rtype = 2'd0;
    endcase
  end

  assign stat.echo = echo_now;
  assign stat.last = in_word.last_char;
  assign stat.is_reg = in_word.opcode;
  assign stat.early_error = phase == PH_SEEK || phase == PH_EQ ||
                            name_length > LenW'(NameMax);
  assign stat.walk_end = walk_idx == (IdxW+1)'(Entries);
  assign stat.hit = whit && walk_idx != (IdxW+1)'(Entries);
  assign stat.hit_missing = !entry_handlers[widx][rtype];
  assign stat.matched = matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Entries; i++) begin
        entry_hash[i] <= '0;
        entry_handlers[i] <= '0;
      end
      name_hash <= HashSeed;
      phase <= PH_SEEK;
      progress <= '0;
      name_length <= '0;
      walk_idx <= '0;
      matched <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (in_word.opcode) begin
          if (in_word.last_char) begin
            if (free_found) begin
              entry_hash[free_idx] <= hash_step;
              entry_handlers[free_idx] <= in_word.handler_mask;
            end
            name_hash <= HashSeed;
            name_length <= '0;
            phase <= PH_SEEK;
            progress <= '0;
          end else begin
            name_hash <= hash_step;
            name_length <= len_inc;
          end
        end else begin
          unique case (phase)
            PH_SEEK: begin
              if (mnext == 2'd3) begin
                progress <= '0;
                phase <= PH_NAME;
              end else begin
                progress <= mnext;
              end
            end
            PH_NAME: begin
              if (in_word.char_code == ChQuestion) phase <= PH_READ;
              else if (in_word.char_code == ChEquals) phase <= PH_EQ;
              else begin
                name_hash <= hash_step;
                name_length <= len_inc;
              end
            end
            PH_EQ: phase <= (in_word.char_code == ChQuestion) ? PH_TEST : PH_WRITE;
            default: ;
          endcase
        end
      end
      if (cmd.walk_start) begin
        walk_idx <= '0;
        matched <= 1'b0;
      end
      if (cmd.walk_step) begin
        walk_idx <= walk_idx + 1'b1;
        if (whit) matched <= 1'b1;
      end
      if (cmd.clear_line) begin
        name_hash <= HashSeed;
        name_length <= '0;
        phase <= PH_SEEK;
        progress <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && echo_now) begin
      result <= '{KIND_VALUE, 2'd0, 4'd0, in_word.char_code, 3'd0, 1'b0};
    end else if (cmd.load_result) begin
      if (phase == PH_SEEK)
        result <= '{KIND_ERROR, 2'd0, 4'd0, 8'd0, ERR_NO_MARKER, 1'b1};
      else if (phase == PH_EQ)
        result <= '{KIND_ERROR, 2'd0, 4'd0, 8'd0, ERR_EQ_LAST, 1'b1};
      else if (name_length > LenW'(NameMax))
        result <= '{KIND_ERROR, rtype, 4'd0, 8'd0, ERR_TOO_LONG, 1'b1};
      else if (walk_idx == (IdxW+1)'(Entries))
        result <= '{KIND_ERROR, rtype, 4'd0, 8'd0, ERR_NO_MATCH, 1'b1};
      else if (!entry_handlers[widx][rtype])
        result <= '{KIND_ERROR, rtype, 4'(widx), 8'd0, ERR_NO_HANDLER, 1'b1};
      else
        result <= '{KIND_DISPATCH, rtype, 4'(widx), 8'd0, 3'd0, 1'b0};
    end
  end
endmodule
`default_nettype wire

### src/atcd_ctrl.sv
// Controller: sequences input words, echo, line-end walk and result handshake.
// Depends on atcd_pkg; commands atcd_datapath.
`default_nettype none
module atcd_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  atcd_pkg::stat_t     stat,
  output atcd_pkg::cmd_t      cmd,
  output logic                last_fix
);
  import atcd_pkg::*;

  state_t state, state_next;
  logic   pend_last, pend_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend_last <= 1'b0;
    end else begin
      state <= state_next;
      pend_last <= pend_last_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_last_next = pend_last;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    last_fix = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.is_reg) begin
            state_next = ST_IDLE;
          end else if (stat.echo) begin
            pend_last_next = stat.last;
            state_next = ST_ECHO;
          end else if (stat.last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_ECHO: begin
        out_valid = 1'b1;
        if (out_ready) state_next = pend_last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (stat.early_error) begin
          cmd.load_result = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.walk_start = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat.walk_end) begin
          if (stat.matched) begin
            cmd.clear_line = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.load_result = 1'b1;
            state_next = ST_DONE;
          end
        end else if (stat.hit) begin
          cmd.load_result = 1'b1;
          state_next = stat.hit_missing ? ST_DONE : ST_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        last_fix = 1'b1;
        if (out_ready) begin
          cmd.walk_step = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear_line = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/atcd_lookahead.sv
// Last-dispatch lookahead: flags whether any later slot also matches.
// Depends on atcd_pkg; takes the later-hit flag from the datapath.
`default_nettype none
module atcd_lookahead (
  input  atcd_pkg::out_word_t  dp_result,
  input  wire                  is_emit,
  input  wire                  later_hit,
  output atcd_pkg::out_word_t  result
);
  import atcd_pkg::*;

  always_comb begin
    result = dp_result;
    if (is_emit) result.last_result = !later_hit;
  end
endmodule
`default_nettype wire

### src/at_command_line_dispatcher_top.sv
// AT command line dispatcher, top level.
// Takes one character or registration word per cycle, but holds input
// while an echo word waits to be taken and while a line end is handled:
// an early-error check, a walk over the table slots emitting a word per
// match, and closing the walk. Sync reset clears table and parser.
// Depends on atcd_pkg, atcd_datapath, atcd_ctrl, atcd_lookahead.
`default_nettype none
module at_command_line_dispatcher_top (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  atcd_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output atcd_pkg::out_word_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [23:0]           cfg_data
);
  import atcd_pkg::*;

  logic [23:0] marker_chars;
  cmd_t        cmd;
  stat_t       stat;
  out_word_t   dp_result;
  logic        is_emit;
  logic        later_hit;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) marker_chars <= 24'h41542B;
    else if (cfg_valid) marker_chars <= cfg_data;
  end

  atcd_datapath u_dp (
    .clk, .rst, .marker_chars, .in_word(in_data), .cmd, .stat, .later_hit,
    .result(dp_result)
  );

  atcd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd,
    .last_fix(is_emit)
  );

  atcd_lookahead u_la (
    .dp_result, .is_emit, .later_hit, .result(out_data)
  );

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !out_valid)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_ERROR) |-> out_data.last_result)
    else $error("error word not last");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_VALUE) |-> !out_data.last_result)
    else $error("echo word marked last");
endmodule
`default_nettype wire
